// ===== sv/tat_pkg.sv =====
// ----------------------------------------------------------------------------
// tat_pkg
// Shared widths, constants and types for the thermistor temperature pipeline.
// ----------------------------------------------------------------------------
package tat_pkg;

  localparam int ADC_BITS_DEF = 16;
  localparam int CODE_W       = 16;
  localparam int OHM_W        = 20;
  localparam int CK_W         = 16;
  localparam int BETA_W       = 16;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  // register map, word index
  typedef enum logic [1:0] {
    REG_SERIES  = 2'd0,
    REG_NOMINAL = 2'd1,
    REG_NOM_CK  = 2'd2,
    REG_BETA    = 2'd3
  } reg_idx_t;

  // log2 unit: 40-bit operand, Q32 result with 6 integer bits
  localparam int X_W    = 40;
  localparam int E_W    = 6;
  localparam int FRAC_W = 32;
  localparam int LOG_W  = E_W + FRAC_W;

  localparam logic [FRAC_W-1:0] LN2_Q32 = 32'd2977044472;
  localparam int LND_W  = 39;
  localparam int TERM_W = CK_W + LND_W;
  localparam int BASE_HI_W = 23;
  localparam int DM_W   = 56;

  // long division: numerator 10*n*b in Q48 over 84 quotient bits
  localparam int NUM_W     = 36;
  localparam int DIV_STEPS = 84;
  localparam int DIV_FRAC  = 48;
  localparam int Q_W       = 40;

  localparam int MAG_W = Q_W + 1;
  localparam logic [Q_W-1:0] OFFSET_Q16 = 40'd179011584;  // 2731.5 K*10 in Q16

  localparam int T_W = 16;
  localparam logic [T_W-1:0] T_POS_SAT = 16'h7FFF;
  localparam logic [T_W-1:0] T_NEG_SAT = 16'h8000;
  localparam logic [T_W-1:0] T_ABS_ZERO = 16'hF555;       // -2731
  localparam logic [MAG_W-T_W-1:0] T_POS_MAX = 25'd32767;
  localparam logic [MAG_W-T_W-1:0] T_NEG_MAX = 25'd32768;

  typedef struct packed {
    logic valid;
    logic zero;
  } tag_t;

  typedef struct packed {
    logic [OHM_W-1:0]     series;
    logic [OHM_W-1:0]     nominal;
    logic [CK_W-1:0]      nom_ck;
    logic [BETA_W-1:0]    beta;
    logic [NUM_W-1:0]     num;
    logic [BASE_HI_W-1:0] base_hi;
  } cfg_t;

endpackage

// ===== sv/tat_cfg.sv =====
// ----------------------------------------------------------------------------
// tat_cfg
// APB register file for the divider and beta parameters, plus derived terms.
// ----------------------------------------------------------------------------
module tat_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tat_pkg::ADDR_W-1:0] paddr,
  input  logic [tat_pkg::DATA_W-1:0] pwdata,
  output logic [tat_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output tat_pkg::cfg_t              cfg
);

  logic [tat_pkg::OHM_W-1:0]     series;
  logic [tat_pkg::OHM_W-1:0]     nominal;
  logic [tat_pkg::CK_W-1:0]      nom_ck;
  logic [tat_pkg::BETA_W-1:0]    beta;
  logic [31:0]                   nb;
  logic [tat_pkg::NUM_W-1:0]     num;
  logic [tat_pkg::BASE_HI_W-1:0] base_hi;
  logic                          wr;
  tat_pkg::reg_idx_t             idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = tat_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      series  <= 20'd470;
      nominal <= 20'd1100;
      nom_ck  <= 16'd29315;
      beta    <= 16'd3572;
    end else if (wr) begin
      case (idx)
        tat_pkg::REG_SERIES:  series  <= pwdata[tat_pkg::OHM_W-1:0];
        tat_pkg::REG_NOMINAL: nominal <= pwdata[tat_pkg::OHM_W-1:0];
        tat_pkg::REG_NOM_CK:  nom_ck  <= pwdata[tat_pkg::CK_W-1:0];
        tat_pkg::REG_BETA:    beta    <= pwdata[tat_pkg::BETA_W-1:0];
        default: ;
      endcase
    end
  end

  // derived terms, registered: nb from nom_ck and beta, then num from nb; base_hi from beta
  always_ff @(posedge clk) begin
    nb      <= nom_ck * beta;
    num     <= {1'b0, nb, 3'b000} + {3'b000, nb, 1'b0};
    base_hi <= tat_pkg::BASE_HI_W'(beta) * tat_pkg::BASE_HI_W'(7'd100);
  end

  always_comb begin
    case (idx)
      tat_pkg::REG_SERIES:  prdata = {12'd0, series};
      tat_pkg::REG_NOMINAL: prdata = {12'd0, nominal};
      tat_pkg::REG_NOM_CK:  prdata = {16'd0, nom_ck};
      tat_pkg::REG_BETA:    prdata = {16'd0, beta};
      default:              prdata = '0;
    endcase
  end

  assign cfg.series  = series;
  assign cfg.nominal = nominal;
  assign cfg.nom_ck  = nom_ck;
  assign cfg.beta    = beta;
  assign cfg.num     = num;
  assign cfg.base_hi = base_hi;

endmodule

// ===== sv/tat_log2.sv =====
// ----------------------------------------------------------------------------
// tat_log2
// Two-lane pipelined log2 in Q32: two normalize stages, then one squaring
// stage per fraction bit.
// ----------------------------------------------------------------------------
module tat_log2 (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  tat_pkg::tag_t             tag_in,
  input  logic [tat_pkg::X_W-1:0]   x_in,
  input  logic [tat_pkg::X_W-1:0]   y_in,
  output tat_pkg::tag_t             tag_out,
  output logic [tat_pkg::LOG_W-1:0] lx_out,
  output logic [tat_pkg::LOG_W-1:0] ly_out
);

  localparam int XW = tat_pkg::X_W;
  localparam int FW = tat_pkg::FRAC_W;
  localparam int EW = tat_pkg::E_W;

  logic [XW-1:0] opd [2];
  logic [XW-1:0] w1 [2];
  logic [2:0]    lzh [2];
  logic [FW-1:0] m_s [2][FW+1];
  logic [FW-1:0] f_s [2][FW+1];
  logic [EW-1:0] e_s [2][FW+1];
  tat_pkg::tag_t tag1;
  tat_pkg::tag_t tag_s [FW+1];

  assign opd[0] = x_in;
  assign opd[1] = y_in;

  for (genvar j = 0; j < 2; j++) begin : g_lane
    logic [XW-1:0] s1, s2, s3, u1, u2, u3;
    logic z32, z16, z8, z4, z2, z1;
    logic [EW-1:0] lz;

    // coarse shifts by 32, 16, 8
    always_comb begin
      z32 = (opd[j][XW-1 -: 32] == '0);
      s1  = z32 ? (opd[j] << 32) : opd[j];
      z16 = (s1[XW-1 -: 16] == '0);
      s2  = z16 ? (s1 << 16) : s1;
      z8  = (s2[XW-1 -: 8] == '0);
      s3  = z8 ? (s2 << 8) : s2;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        w1[j]  <= s3;
        lzh[j] <= {z32, z16, z8};
      end
    end

    // fine shifts by 4, 2, 1
    always_comb begin
      z4 = (w1[j][XW-1 -: 4] == '0);
      u1 = z4 ? (w1[j] << 4) : w1[j];
      z2 = (u1[XW-1 -: 2] == '0);
      u2 = z2 ? (u1 << 2) : u1;
      z1 = !u2[XW-1];
      u3 = z1 ? (u2 << 1) : u2;
      lz = {lzh[j], z4, z2, z1};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_s[j][0] <= u3[XW-1 -: FW];
        f_s[j][0] <= '0;
        e_s[j][0] <= EW'(XW - 1) - lz;
      end
    end

    for (genvar k = 0; k < FW; k++) begin : g_sq
      logic [2*FW-1:0] p;
      logic [FW:0]     t;
      always_comb begin
        p = m_s[j][k] * m_s[j][k];
        t = p[2*FW-1:FW-1];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          m_s[j][k+1] <= t[FW] ? t[FW:1] : t[FW-1:0];
          f_s[j][k+1] <= {f_s[j][k][FW-2:0], t[FW]};
          e_s[j][k+1] <= e_s[j][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      for (int i = 0; i <= FW; i++) tag_s[i] <= '0;
    end else if (en) begin
      tag1     <= tag_in;
      tag_s[0] <= tag1;
      for (int i = 1; i <= FW; i++) tag_s[i] <= tag_s[i-1];
    end
  end

  assign tag_out = tag_s[FW];
  assign lx_out  = {e_s[0][FW], f_s[0][FW]};
  assign ly_out  = {e_s[1][FW], f_s[1][FW]};

endmodule

// ===== sv/tat_den.sv =====
// ----------------------------------------------------------------------------
// tat_den
// Beta-equation denominator 100*B*2^32 +/- n*ln(R/R0), five stages.
// ----------------------------------------------------------------------------
module tat_den (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [tat_pkg::CK_W-1:0]      nom_ck,
  input  logic [tat_pkg::BASE_HI_W-1:0] base_hi,
  input  tat_pkg::tag_t                 tag_in,
  input  logic [tat_pkg::LOG_W-1:0]     lx,
  input  logic [tat_pkg::LOG_W-1:0]     ly,
  output tat_pkg::tag_t                 tag_out,
  output logic [tat_pkg::DM_W-1:0]      dmag,
  output logic                          dneg
);

  localparam int LW = tat_pkg::LOG_W;
  localparam int FW = tat_pkg::FRAC_W;

  tat_pkg::tag_t tg [4];
  logic [LW-1:0] a1;
  logic          ln1, ln2, ln3, ln4;
  logic [LW-1:0] hi2;
  logic [FW-1:0] lo2;
  logic [2*FW-1:0] lo_full;
  logic [tat_pkg::LND_W-1:0]  lnd3;
  logic [tat_pkg::TERM_W-1:0] term4;
  logic [tat_pkg::TERM_W-1:0] base;

  assign lo_full = a1[FW-1:0] * tat_pkg::LN2_Q32;
  assign base    = {base_hi, {FW{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      ln1   <= lx < ly;
      a1    <= (lx < ly) ? (ly - lx) : (lx - ly);
      ln2   <= ln1;
      hi2   <= LW'(a1[LW-1:FW]) * LW'(tat_pkg::LN2_Q32);
      lo2   <= lo_full[2*FW-1:FW];
      ln3   <= ln2;
      lnd3  <= tat_pkg::LND_W'(hi2) + tat_pkg::LND_W'(lo2);
      ln4   <= ln3;
      term4 <= nom_ck * lnd3;
      if (!ln4) begin
        dmag <= tat_pkg::DM_W'(base) + tat_pkg::DM_W'(term4);
        dneg <= 1'b0;
      end else if (base >= term4) begin
        dmag <= tat_pkg::DM_W'(base - term4);
        dneg <= 1'b0;
      end else begin
        dmag <= tat_pkg::DM_W'(term4 - base);
        dneg <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) tg[i] <= '0;
      tag_out <= '0;
    end else if (en) begin
      tg[0] <= tag_in;
      for (int i = 1; i < 4; i++) tg[i] <= tg[i-1];
      tag_out <= tg[3];
    end
  end

endmodule

// ===== sv/tat_div.sv =====
// ----------------------------------------------------------------------------
// tat_div
// Restoring long division, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module tat_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [tat_pkg::NUM_W-1:0] num,
  input  tat_pkg::tag_t             tag_in,
  input  logic [tat_pkg::DM_W-1:0]  dmag_in,
  input  logic                      dneg_in,
  output tat_pkg::tag_t             tag_out,
  output logic [tat_pkg::Q_W-1:0]   q_out,
  output logic                      huge_out,
  output logic                      dneg_out
);

  localparam int N  = tat_pkg::DIV_STEPS;
  localparam int DW = tat_pkg::DM_W;
  localparam int QW = tat_pkg::Q_W;

  logic [DW-1:0] r_s  [N];
  logic [DW-1:0] dm_s [N];
  logic [QW-1:0] q_s  [N];
  logic          hg_s [N];
  logic          dn_s [N];
  tat_pkg::tag_t tag_s [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int I = N - 1 - k;
    logic [DW-1:0] r_c, dm_c;
    logic [QW-1:0] q_c;
    logic          hg_c, dn_c, dbit, ge;
    tat_pkg::tag_t tg_c;
    logic [DW:0]   rt;

    if (k == 0) begin : g_first
      assign r_c  = '0;
      assign dm_c = dmag_in;
      assign q_c  = '0;
      assign hg_c = (dmag_in == '0);
      assign dn_c = dneg_in;
      assign tg_c = tag_in;
    end else begin : g_next
      assign r_c  = r_s[k-1];
      assign dm_c = dm_s[k-1];
      assign q_c  = q_s[k-1];
      assign hg_c = hg_s[k-1];
      assign dn_c = dn_s[k-1];
      assign tg_c = tag_s[k-1];
    end

    if (I >= tat_pkg::DIV_FRAC) begin : g_num
      assign dbit = num[I-tat_pkg::DIV_FRAC];
    end else begin : g_pad
      assign dbit = 1'b0;
    end

    assign rt = {r_c, dbit};
    assign ge = rt >= {1'b0, dm_c};

    always_ff @(posedge clk) begin
      if (en) begin
        r_s[k]  <= ge ? DW'(rt - {1'b0, dm_c}) : rt[DW-1:0];
        q_s[k]  <= {q_c[QW-2:0], ge};
        hg_s[k] <= hg_c | q_c[QW-1];   // quotient reached 2^40
        dm_s[k] <= dm_c;
        dn_s[k] <= dn_c;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_s[k] <= '0;
      end else if (en) begin
        tag_s[k] <= tg_c;
      end
    end
  end

  assign tag_out  = tag_s[N-1];
  assign q_out    = q_s[N-1];
  assign huge_out = hg_s[N-1];
  assign dneg_out = dn_s[N-1];

endmodule

// ===== sv/thermistor_adc_to_temperature.sv =====
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature
// Path: input register, 34-stage log2 lanes, denominator, 84-stage divider,
// offset and output registers. Throughput: one item per cycle unless stalled.
// The whole pipeline holds while a result is stalled at the output register.
// Reset (synchronous) empties the pipeline and restores the default registers.
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature #(
  parameter int ADC_BITS = tat_pkg::ADC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tat_pkg::ADDR_W-1:0] paddr,
  input  logic [tat_pkg::DATA_W-1:0] pwdata,
  output logic [tat_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  input  logic [tat_pkg::CODE_W-1:0] adc_code,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [tat_pkg::T_W-1:0] temperature_deci_c,
  output logic                       clipped
);

  localparam int XW = tat_pkg::X_W;
  localparam int MW = tat_pkg::MAG_W;
  localparam int TW = tat_pkg::T_W;

  tat_pkg::cfg_t cfg;
  logic          en;

  logic [ADC_BITS-1:0]        code_m;
  logic [ADC_BITS:0]          fc;
  logic [tat_pkg::OHM_W+ADC_BITS-1:0] xp;
  logic [tat_pkg::OHM_W+ADC_BITS:0]   yp;
  logic [XW-1:0]              x0, y0;
  tat_pkg::tag_t              tag0, tag_l, tag_d, tag_q, tag_f;
  logic [tat_pkg::LOG_W-1:0]  lx, ly;
  logic [tat_pkg::DM_W-1:0]   dmag;
  logic                       dneg, q_dneg, q_huge;
  logic [tat_pkg::Q_W-1:0]    q;
  logic [MW-1:0]              f_mag;
  logic                       f_neg, f_huge, f_dneg;
  logic [MW-TW-1:0]           res_mag;
  logic [TW-1:0]              res_next;
  logic                       clip_next;

  assign en           = !(result_valid && result_stall);
  assign sample_stall = result_valid && result_stall;

  tat_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  // divider resistances: x from the series side, y from the nominal side
  assign code_m = adc_code[ADC_BITS-1:0];
  assign fc     = {1'b1, {ADC_BITS{1'b0}}} - {1'b0, code_m};
  assign xp     = cfg.series * code_m;
  assign yp     = cfg.nominal * fc;

  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= XW'(xp);
      y0 <= XW'(yp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag0 <= '0;
    end else if (en) begin
      tag0.valid <= sample_valid;
      tag0.zero  <= (code_m == '0) || (cfg.series == '0) || (cfg.nominal == '0)
                    || (cfg.nom_ck == '0) || (cfg.beta == '0);
    end
  end

  tat_log2 u_log (
    .clk(clk), .rst(rst), .en(en), .tag_in(tag0), .x_in(x0), .y_in(y0),
    .tag_out(tag_l), .lx_out(lx), .ly_out(ly)
  );

  tat_den u_den (
    .clk(clk), .rst(rst), .en(en), .nom_ck(cfg.nom_ck), .base_hi(cfg.base_hi),
    .tag_in(tag_l), .lx(lx), .ly(ly), .tag_out(tag_d), .dmag(dmag), .dneg(dneg)
  );

  tat_div u_div (
    .clk(clk), .rst(rst), .en(en), .num(cfg.num), .tag_in(tag_d),
    .dmag_in(dmag), .dneg_in(dneg), .tag_out(tag_q), .q_out(q),
    .huge_out(q_huge), .dneg_out(q_dneg)
  );

  // signed 10*T - 2731.5 in Q16, as sign and magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      f_huge <= q_huge;
      f_dneg <= q_dneg;
      if (q_dneg) begin
        f_mag <= MW'(q) + MW'(tat_pkg::OFFSET_Q16);
        f_neg <= 1'b1;
      end else if (q >= tat_pkg::OFFSET_Q16) begin
        f_mag <= MW'(q - tat_pkg::OFFSET_Q16);
        f_neg <= 1'b0;
      end else begin
        f_mag <= MW'(tat_pkg::OFFSET_Q16 - q);
        f_neg <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_f <= '0;
    end else if (en) begin
      tag_f <= tag_q;
    end
  end

  assign res_mag = f_mag[MW-1:16];

  always_comb begin
    res_next  = tat_pkg::T_POS_SAT;
    clip_next = 1'b0;
    if (tag_f.zero) begin
      res_next = tat_pkg::T_ABS_ZERO;
    end else if (f_huge) begin
      res_next  = f_dneg ? tat_pkg::T_NEG_SAT : tat_pkg::T_POS_SAT;
      clip_next = 1'b1;
    end else if (f_neg) begin
      if (res_mag > tat_pkg::T_NEG_MAX) begin
        res_next  = tat_pkg::T_NEG_SAT;
        clip_next = 1'b1;
      end else begin
        res_next = TW'(~res_mag[TW-1:0] + 1'b1);
      end
    end else if (res_mag > tat_pkg::T_POS_MAX) begin
      clip_next = 1'b1;
    end else begin
      res_next = res_mag[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temperature_deci_c <= res_next;
      clipped            <= clip_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= tag_f.valid;
    end
  end

endmodule
